### rtl/rist_pkg.sv
// Shared types and constants for the random interval switch toggler.
package rist_pkg;

    // Widths of the ports and of the datapath
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned RAND_W   = 31;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CNT_W    = 5;

    // Timer step subtracted on each tick that counts the timer down, in milliseconds
    localparam logic [DATA_W-1:0] TICK_DECREMENT = 32'd5;

    // Bound register reset values (one day on, five seconds off)
    localparam logic [DATA_W-1:0] ON_BOUND_RST  = 32'd86400000;
    localparam logic [DATA_W-1:0] OFF_BOUND_RST = 32'd5000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ON_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_MAX = 2'd3;

    // Toggle phase of the channel
    typedef enum logic [1:0] {
        PH_INIT     = 2'd0,
        PH_WAIT_ON  = 2'd1,
        PH_WAIT_OFF = 2'd2
    } t_phase;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_ADD,
        S_CHECK,
        S_OUT
    } t_state;

endpackage

### rtl/random_interval_switch_toggler_unit.sv
// Top level: one channel of a random interval load switch with a serial modulo unit.
//
// Each accepted input word is one timer tick and yields one output word, the switch
// level after that tick. A tick that only counts the timer down passes through the
// evaluation, timer check and output states; a tick in a forced mode skips the check.
// A tick that draws a new duration runs 31 steps of the shared restoring-remainder
// unit per draw, one per random bit, plus the bound add, or only the add when the span
// wraps to zero. At most two draws occur per tick. The input side is not ready until
// the tick is finished and its result has been moved into the output register, so a
// full output register stalls the input. The user must write the bound registers
// through the configuration port only while the block is idle; the block itself does
// not enforce this. The configuration port is always ready.
module random_interval_switch_toggler_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [rist_pkg::RAND_W-1:0]      i_random_a,
    input  logic [rist_pkg::RAND_W-1:0]      i_random_b,
    // output channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_switch_on,
    // configuration channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rist_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rist_pkg::DATA_W-1:0]      i_cfg_data
);
    import rist_pkg::*;

    // Sequencer and configuration
    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_on_min, r_on_max, r_off_min, r_off_max;

    // Channel state
    t_phase              r_phase, n_phase;
    logic [DATA_W-1:0]   r_remain, n_remain;
    logic                r_drive, n_drive;

    // Tick words and draw bookkeeping
    logic [RAND_W-1:0]   r_rand_a, r_rand_b;
    logic                r_drawn, n_drawn;
    logic                r_reload, n_reload;

    // Shared remainder unit
    logic [DATA_W-1:0]   r_lo, n_lo;
    logic [DATA_W-1:0]   r_div, n_div;
    logic [DATA_W-1:0]   r_rem, n_rem;
    logic [RAND_W-1:0]   r_word, n_word;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // Output register
    logic                r_out_valid, n_out_valid;
    logic                r_out, n_out;

    logic                w_accept;
    logic                w_forced_off, w_forced_on;
    logic [DATA_W-1:0]   w_cur_lo, w_cur_hi, w_next_lo, w_next_hi;
    logic                w_stale, w_expired;
    logic                w_eval_draw, w_check_draw, w_start;
    logic [DATA_W-1:0]   w_draw_lo, w_draw_hi, w_span;
    logic [RAND_W-1:0]   w_draw_word;
    logic [DATA_W:0]     w_shift;
    logic [DATA_W+1:0]   w_diff;
    logic                w_ge;
    logic                w_load_out;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_switch_on = r_out;
    assign w_accept    = i_valid && o_ready;

    // Decode mode from the bounds
    assign w_forced_off = (r_on_min == '0) && (r_on_max == '0);
    assign w_forced_on  = (r_off_min == '0) && (r_off_max == '0);

    // Bounds of the phase being timed and of the one that follows
    assign w_cur_lo  = (r_phase == PH_WAIT_OFF) ? r_on_min  : r_off_min;
    assign w_cur_hi  = (r_phase == PH_WAIT_OFF) ? r_on_max  : r_off_max;
    assign w_next_lo = (r_phase == PH_WAIT_OFF) ? r_off_min : r_on_min;
    assign w_next_hi = (r_phase == PH_WAIT_OFF) ? r_off_max : r_on_max;

    assign w_stale   = (r_remain > w_cur_lo) && (r_remain > w_cur_hi);
    assign w_expired = (r_remain <= TICK_DECREMENT);

    // Decide where a draw starts and from which bounds
    assign w_eval_draw  = (r_state == S_EVAL) && !w_forced_off && !w_forced_on &&
                          ((r_phase == PH_INIT) ||
                           (((r_phase == PH_WAIT_ON) || (r_phase == PH_WAIT_OFF)) && w_stale));
    assign w_check_draw = (r_state == S_CHECK) && w_expired;
    assign w_start      = w_eval_draw || w_check_draw;

    assign w_draw_lo   = (r_state == S_CHECK) ? w_next_lo :
                         (r_phase == PH_INIT) ? r_on_min  : w_cur_lo;
    assign w_draw_hi   = (r_state == S_CHECK) ? w_next_hi :
                         (r_phase == PH_INIT) ? r_on_max  : w_cur_hi;
    assign w_span      = w_draw_hi - w_draw_lo + 32'd1;
    assign w_draw_word = r_drawn ? r_rand_b : r_rand_a;

    // One restoring remainder step: shift in the next random bit, subtract if it fits
    assign w_shift = {r_rem, r_word[RAND_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_ge    = !w_diff[DATA_W+1];

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_eval_draw) n_state = (w_span == '0) ? S_ADD : S_DIV;
                else if (!w_forced_off && !w_forced_on &&
                         ((r_phase == PH_WAIT_ON) || (r_phase == PH_WAIT_OFF)))
                    n_state = S_CHECK;
                else n_state = S_OUT;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_ADD;
            end
            S_ADD: begin
                n_state = r_reload ? S_OUT : S_CHECK;
            end
            S_CHECK: begin
                if (w_check_draw) n_state = (w_span == '0) ? S_ADD : S_DIV;
                else n_state = S_OUT;
            end
            S_OUT: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_phase     = r_phase;
        n_remain    = r_remain;
        n_drive     = r_drive;
        n_drawn     = r_drawn;
        n_reload    = r_reload;
        n_lo        = r_lo;
        n_div       = r_div;
        n_rem       = r_rem;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the output word once taken
        if (r_out_valid && i_ready) n_out_valid = 1'b0;

        // load the shared unit for a new draw
        if (w_start) begin
            n_lo    = w_draw_lo;
            n_div   = w_span;
            n_word  = w_draw_word;
            n_rem   = (w_span == '0) ? {{(DATA_W-RAND_W){1'b0}}, w_draw_word} : '0;
            n_cnt   = CNT_W'(RAND_W - 1);
            n_drawn = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) n_drawn = 1'b0;
            end
            S_EVAL: begin
                if (w_forced_off) n_drive = 1'b0;
                else if (w_forced_on) n_drive = 1'b1;
                else if (r_phase == PH_INIT) begin
                    n_drive  = 1'b1;
                    n_phase  = PH_WAIT_OFF;
                    n_reload = 1'b1;
                end else begin
                    n_reload = 1'b0;
                end
            end
            S_DIV: begin
                // advance one remainder step
                n_rem  = w_ge ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
                n_word = {r_word[RAND_W-2:0], 1'b0};
                n_cnt  = r_cnt - CNT_W'(1);
            end
            S_ADD: begin
                n_remain = r_rem + r_lo;
            end
            S_CHECK: begin
                if (w_expired) begin
                    n_drive  = (r_phase == PH_WAIT_ON);
                    n_phase  = (r_phase == PH_WAIT_OFF) ? PH_WAIT_ON : PH_WAIT_OFF;
                    n_reload = 1'b1;
                end else begin
                    n_remain = r_remain - TICK_DECREMENT;
                end
            end
            S_OUT: begin
                if (w_load_out) begin
                    n_out       = r_drive;
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_on_min    <= ON_BOUND_RST;
            r_on_max    <= ON_BOUND_RST;
            r_off_min   <= OFF_BOUND_RST;
            r_off_max   <= OFF_BOUND_RST;
            r_phase     <= PH_INIT;
            r_remain    <= '0;
            r_drive     <= 1'b1;
            r_drawn     <= 1'b0;
            r_reload    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_remain    <= n_remain;
            r_drive     <= n_drive;
            r_drawn     <= n_drawn;
            r_reload    <= n_reload;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ON_MIN:  r_on_min  <= i_cfg_data;
                    REG_ON_MAX:  r_on_max  <= i_cfg_data;
                    REG_OFF_MIN: r_off_min <= i_cfg_data;
                    REG_OFF_MAX: r_off_max <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rand_a <= i_random_a;
            r_rand_b <= i_random_b;
        end
        r_lo   <= n_lo;
        r_div  <= n_div;
        r_rem  <= n_rem;
        r_word <= n_word;
        r_out  <= n_out;
    end

    // Partial remainder stays below the divisor while stepping
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    // An accepted tick goes straight to evaluation
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EVAL))
        else $error("accepted tick not evaluated");

    // After the bound add the tick either finishes or checks the timer
    a_add_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> ((r_state == S_OUT) || (r_state == S_CHECK)))
        else $error("bad sequence after bound add");

    // Forced off mode always leaves the switch off
    a_forced_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && w_forced_off) |-> !r_drive)
        else $error("switch on in forced off mode");

endmodule

### tb/tb.sv
// Self-checking testbench for the random interval switch toggler unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rist_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned PAUSE_AT     = 600;
    localparam logic [RAND_W-1:0] RAND_MAX = '1;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    // Tracks the switch level tick by tick and queues the expected output words
    class level_tracker;
        logic [DATA_W-1:0] on_min, on_max, off_min, off_max;
        t_phase            phase;
        logic [DATA_W-1:0] remaining;
        bit                level;
        logic [RAND_W-1:0] word_a, word_b;
        int                draws;
        bit                expected_levels[$];
        int                mismatches;

        function new();
            on_min     = ON_BOUND_RST;
            on_max     = ON_BOUND_RST;
            off_min    = OFF_BOUND_RST;
            off_max    = OFF_BOUND_RST;
            phase      = PH_INIT;
            remaining  = '0;
            level      = 1'b1;
            mismatches = 0;
        endfunction

        function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ON_MIN:  on_min  = value;
                REG_ON_MAX:  on_max  = value;
                REG_OFF_MIN: off_min = value;
                REG_OFF_MAX: off_max = value;
                default: ;
            endcase
        endfunction

        // First draw of a tick takes word a, any later one word b
        function logic [DATA_W-1:0] draw_duration(logic [DATA_W-1:0] lo,
                                                  logic [DATA_W-1:0] hi);
            logic [DATA_W-1:0] r;
            logic [DATA_W-1:0] span;
            r    = {1'b0, (draws == 0) ? word_a : word_b};
            span = hi - lo + 32'd1;
            draws++;
            if (span == '0)
                return r + lo;
            return (r % span) + lo;
        endfunction

        // Count down one waiting phase, flip and reload when the timer runs out
        function void run_wait(logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                               logic [DATA_W-1:0] next_lo, logic [DATA_W-1:0] next_hi,
                               bit new_level, t_phase next_phase);
            if (remaining > lo && remaining > hi)
                remaining = draw_duration(lo, hi);
            if (remaining > TICK_DECREMENT) begin
                remaining = remaining - TICK_DECREMENT;
            end else begin
                level     = new_level;
                remaining = draw_duration(next_lo, next_hi);
                phase     = next_phase;
            end
        endfunction

        function void note_tick(logic [RAND_W-1:0] a, logic [RAND_W-1:0] b);
            word_a = a;
            word_b = b;
            draws  = 0;
            if (on_min == '0 && on_max == '0) begin
                level = 1'b0;
            end else if (off_min == '0 && off_max == '0) begin
                level = 1'b1;
            end else begin
                case (phase)
                    PH_INIT: begin
                        level     = 1'b1;
                        remaining = draw_duration(on_min, on_max);
                        phase     = PH_WAIT_OFF;
                    end
                    PH_WAIT_OFF: run_wait(on_min, on_max, off_min, off_max, 1'b0, PH_WAIT_ON);
                    PH_WAIT_ON:  run_wait(off_min, off_max, on_min, on_max, 1'b1, PH_WAIT_OFF);
                    default: ;
                endcase
            end
            expected_levels.push_back(level);
        endfunction

        function void check_level(bit actual);
            bit want;
            if (expected_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: output word %0d with none expected", actual);
                return;
            end
            want = expected_levels.pop_front();
            if (want !== actual) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: switch_on mismatch, expected %0d got %0d", want, actual);
            end
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [RAND_W-1:0]    i_random_a = '0;
    logic [RAND_W-1:0]    i_random_b = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_switch_on;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DATA_W-1:0]    i_cfg_data = '0;

    level_tracker tracker;
    bit           idle_on = 1'b0;
    bit           hold_done = 1'b0;
    int unsigned  ticks_sent = 0;
    int unsigned  random_sent = 0;
    int unsigned  quiet_cycles = 0;

    random_interval_switch_toggler_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_random_a  (i_random_a),
        .i_random_b  (i_random_b),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_switch_on (o_switch_on),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Check every accepted output word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tracker.check_level(o_switch_on);
    end

    // End the run if no word moves on any channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && ticks_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one tick word and hold it until accepted; maybe idle afterwards
    task automatic send_tick(input logic [RAND_W-1:0] a, input logic [RAND_W-1:0] b);
        i_valid    <= 1'b1;
        i_random_a <= a;
        i_random_b <= b;
        do @(posedge i_clk); while (!o_ready);
        tracker.note_tick(a, b);
        ticks_sent++;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected word has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
    endtask

    // Write all four bounds, starting at a random register
    task automatic configure(input logic [DATA_W-1:0] on_lo, input logic [DATA_W-1:0] on_hi,
                             input logic [DATA_W-1:0] off_lo, input logic [DATA_W-1:0] off_hi);
        logic [DATA_W-1:0]    vals [4];
        logic [CFG_IDX_W-1:0] idx;
        int                   start;
        vals[0] = on_lo;
        vals[1] = on_hi;
        vals[2] = off_lo;
        vals[3] = off_hi;
        start   = $urandom_range(0, 3);
        drain();
        repeat (8) @(negedge i_clk);
        for (int k = 0; k < 4; k++) begin
            idx = CFG_IDX_W'((start + k) % 4);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[idx];
            do @(posedge i_clk); while (!o_cfg_ready);
            tracker.set_bound(idx, vals[idx]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [RAND_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RAND_MAX;
            2:       return RAND_W'($urandom_range(0, 63));
            default: return RAND_W'($urandom());
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_small();
        return DATA_W'($urandom_range(0, 30));
    endfunction

    // Stimulus
    initial begin
        logic [DATA_W-1:0] on_lo, on_hi, off_lo, off_hi;
        int unsigned       burst;
        tracker = new();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_on = 1'b1;

        // Reset bounds: initial draw, then a long on period
        send_tick('0, RAND_MAX);
        send_tick(RAND_MAX, '0);

        // Shrink the bounds so the long timer is stale and gets redrawn
        configure(32'd10, 32'd40, 32'd5, 32'd30);
        send_tick(RAND_MAX, RAND_MAX);
        send_tick('0, '0);
        send_tick(RAND_MAX, '0);
        send_tick('0, RAND_MAX);
        send_tick(RAND_W'(31'h2AAA_AAAA), RAND_W'(31'h5555_5555));
        send_tick(RAND_W'(31'h5555_5555), RAND_W'(31'h2AAA_AAAA));

        // Timer at the step: flip on every tick, second draw from word b
        configure(32'd5, 32'd5, 32'd0, 32'd5);
        send_tick(RAND_MAX, RAND_MAX);
        send_tick('0, RAND_MAX);
        send_tick(RAND_MAX, '0);
        send_tick(RAND_W'(3), RAND_W'(4));

        // Forced off, then forced on
        configure(32'd0, 32'd0, 32'd7, 32'd9);
        send_tick(RAND_MAX, '0);
        send_tick('0, RAND_MAX);
        configure(32'd3, 32'd8, 32'd0, 32'd0);
        send_tick(RAND_MAX, '0);
        send_tick('0, RAND_MAX);

        // Min above max, a zero divisor, and all-ones bounds
        configure(32'd100, 32'd20, 32'd5, 32'd10);
        send_tick(RAND_MAX, RAND_MAX);
        send_tick('0, '0);
        configure(32'd0, ALL_ONES, 32'd0, ALL_ONES);
        send_tick(RAND_MAX, RAND_MAX);
        send_tick('0, RAND_MAX);
        configure(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_tick(RAND_MAX, '0);
        send_tick('0, RAND_MAX);

        // Random phases: new bounds, then a burst of ticks
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    on_lo  = '0;
                    on_hi  = '0;
                    off_lo = pick_small();
                    off_hi = DATA_W'($urandom());
                end
                1: begin
                    on_lo  = pick_small();
                    on_hi  = on_lo + DATA_W'($urandom_range(1, 40));
                    off_lo = '0;
                    off_hi = '0;
                end
                2, 3: begin
                    on_lo  = DATA_W'($urandom());
                    on_hi  = DATA_W'($urandom());
                    off_lo = DATA_W'($urandom());
                    off_hi = DATA_W'($urandom());
                end
                default: begin
                    on_lo  = pick_small();
                    on_hi  = on_lo + DATA_W'($urandom_range(0, 40));
                    off_lo = pick_small();
                    off_hi = off_lo + DATA_W'($urandom_range(0, 40));
                    if ($urandom_range(0, 7) == 0) begin
                        on_lo = on_hi + DATA_W'($urandom_range(1, 20));
                    end
                end
            endcase
            configure(on_lo, on_hi, off_lo, off_hi);
            idle_on = (random_sent < RANDOM_ITEMS - 100) && ($urandom_range(0, 4) != 0);
            burst   = $urandom_range(20, 60);
            for (int unsigned n = 0; n < burst && random_sent < RANDOM_ITEMS; n++) begin
                // Hold off the sender once until the output side has caught up
                if (ticks_sent == PAUSE_AT)
                    drain();
                send_tick(pick_word(), pick_word());
                random_sent++;
            end
        end

        // Wait for the last words, then a margin for anything stray
        idle_on = 1'b0;
        drain();
        repeat (100) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
